>>> rtl/clis_pkg.sv
// ----------------------------------------------------------------------------
// clis_pkg
// Shared types and constants of the continuous life image step block:
// sequencer states, the accumulator control word and register indexes.
// ----------------------------------------------------------------------------
package clis_pkg;

   // sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_SUM    = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   // control word from the sequencer to the shared accumulator
   typedef struct packed {
      logic clear;
      logic add;
   } acc_ctrl_type;

   // register indexes of the configuration port
   localparam logic [2:0] REG_PROCREATION = 3'd0;
   localparam logic [2:0] REG_STABILITY   = 3'd1;
   localparam logic [2:0] REG_STEP        = 3'd2;
   localparam logic [2:0] REG_EXIT_STABLE = 3'd3;
   localparam logic [2:0] REG_WIDTH       = 3'd4;
   localparam logic [2:0] REG_HEIGHT      = 3'd5;

   // register reset values
   localparam logic [10:0] RST_PROCREATION = 11'd510;
   localparam logic [10:0] RST_STABILITY   = 11'd765;
   localparam logic [15:0] RST_STEP        = 16'd2560;
   localparam logic [8:0]  RST_WIDTH       = 9'd256;
   localparam logic [8:0]  RST_HEIGHT      = 9'd256;

   // neighbor tap walk: eight neighbors, then the cell itself
   localparam logic [3:0] TAP_OWN = 4'd8;

   localparam int PIX_W = 8;
   localparam int SUM_W = 11;
   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

endpackage

>>> rtl/clis_frame_ram.sv
// ----------------------------------------------------------------------------
// clis_frame_ram
// Single-port frame memory, one pixel per entry, registered read data,
// read-before-write on the same address.
// ----------------------------------------------------------------------------
module clis_frame_ram #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              addr,
   input  logic [clis_pkg::PIX_W-1:0] wr_data,
   output logic [clis_pkg::PIX_W-1:0] rd_data_ff
);

   logic [clis_pkg::PIX_W-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[addr];
   end

endmodule

>>> rtl/clis_accum.sv
// ----------------------------------------------------------------------------
// clis_accum
// Shared neighbor-sum accumulator: adds one pixel per cycle under control
// of the sequencer.
// ----------------------------------------------------------------------------
module clis_accum (
   input  logic                       clock,
   input  clis_pkg::acc_ctrl_type     ctrl,
   input  logic [clis_pkg::PIX_W-1:0] operand,
   output logic [clis_pkg::SUM_W-1:0] sum_ff
);

   logic [clis_pkg::SUM_W-1:0] sum_in;

   // clear or add one pixel
   always_comb begin
      sum_in = sum_ff;
      if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.add) begin
         sum_in = sum_ff + clis_pkg::SUM_W'(operand);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

endmodule

>>> rtl/continuous_life_image_step_top.sv
// ----------------------------------------------------------------------------
// continuous_life_image_step_top
// Continuous game of life on an 8-bit image with toroidal wrap. The first
// frame is loaded and echoed, then each word yields one pixel of the next
// generation, ping-ponging between two frame memories.
// ----------------------------------------------------------------------------
// Load phase: after accept, the LOAD state writes both frame memories and
//   registers the echoed result once the output register is free. Generation
//   phase: after accept, the SUM state makes nine reads (eight neighbors and the
//   cell) of the single-port current frame memory through the shared accumulator, then UPDATE registers the result.
// Reset (synchronous, active high) clears the sequencer, the positions and
//   the phase; frame memories are not cleared and hold data until loaded.
// ----------------------------------------------------------------------------
module continuous_life_image_step_top #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_in
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] pixel_out
   output logic        rsp_tlast,   // frame_last
   output logic        rsp_tuser,   // [0] frame_stable
   // configuration writes
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WDW   = $clog2(MAX_WIDTH + 1);
   localparam int HDW   = $clog2(MAX_HEIGHT + 1);

   // configuration registers
   logic [10:0] procreation_ff, stability_ff;
   logic [15:0] step_ff;
   logic        exit_stable_ff;
   logic [8:0]  width_ff, height_ff;

   // control state
   clis_pkg::state_type state_ff, state_in;
   logic [3:0]          tap_ff, tap_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic                buffer_ff, buffer_in;
   logic                loaded_ff, loaded_in;
   logic                changed_ff, changed_in;
   logic [7:0]          pixel_ff, pixel_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_pixel_ff, rsp_pixel_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_stable_ff, rsp_stable_in;

   // datapath
   logic [WDW-1:0]     eff_w;
   logic [HDW-1:0]     eff_h;
   logic [WDW-1:0]     w_last;
   logic [HDW-1:0]     h_last;
   logic               row_is_last, col_is_last, frame_last;
   logic [RW-1:0]      row_prev, row_next, row_sel;
   logic [CW-1:0]      col_prev, col_next, col_sel;
   logic [3:0]         tap_sel;
   logic [AW-1:0]      ram_addr;
   logic               wr_a, wr_b;
   logic [7:0]         ram_wdata;
   logic [7:0]         rd_a, rd_b, rd_cur;
   logic [10:0]        nsum;
   clis_pkg::acc_ctrl_type acc_ctrl;
   logic               out_free, accept;
   logic               fall, grow;
   logic [11:0]        twice_sum, band_mid;
   logic [16:0]        up_val;
   logic [15:0]        old_scaled;
   logic [7:0]         new_pix;

   // effective frame dimensions
   always_comb begin
      if (width_ff == '0) begin
         eff_w = WDW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = WDW'(MAX_WIDTH);
      end else begin
         eff_w = WDW'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HDW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = HDW'(MAX_HEIGHT);
      end else begin
         eff_h = HDW'(height_ff);
      end
   end

   // wrapped neighbor rows and columns
   always_comb begin
      w_last      = eff_w - WDW'(1);
      h_last      = eff_h - HDW'(1);
      row_is_last = (HDW'(row_ff) == h_last);
      col_is_last = (WDW'(col_ff) == w_last);
      frame_last  = row_is_last && col_is_last;
      row_prev    = (row_ff == '0) ? RW'(h_last) : row_ff - RW'(1);
      row_next    = row_is_last ? '0 : row_ff + RW'(1);
      col_prev    = (col_ff == '0) ? CW'(w_last) : col_ff - CW'(1);
      col_next    = col_is_last ? '0 : col_ff + CW'(1);
   end

   // tap select: address walk over the 3x3 window
   always_comb begin
      tap_sel = (state_ff == clis_pkg::ST_SUM) ? tap_ff : clis_pkg::TAP_OWN;
      case (tap_sel)
         4'd0, 4'd3, 4'd5: row_sel = row_prev;
         4'd2, 4'd4, 4'd7: row_sel = row_next;
         default:          row_sel = row_ff;
      endcase
      case (tap_sel)
         4'd0, 4'd1, 4'd2: col_sel = col_prev;
         4'd5, 4'd6, 4'd7: col_sel = col_next;
         default:          col_sel = col_ff;
      endcase
      ram_addr = AW'(AW'(row_sel) * AW'(MAX_WIDTH) + AW'(col_sel));
   end

   // frame memories
   clis_frame_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_a (
      .clock      (clock),
      .wr_en      (wr_a),
      .addr       (ram_addr),
      .wr_data    (ram_wdata),
      .rd_data_ff (rd_a)
   );

   clis_frame_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_b (
      .clock      (clock),
      .wr_en      (wr_b),
      .addr       (ram_addr),
      .wr_data    (ram_wdata),
      .rd_data_ff (rd_b)
   );

   assign rd_cur = buffer_ff ? rd_b : rd_a;

   // shared neighbor accumulator
   clis_accum u_accum (
      .clock   (clock),
      .ctrl    (acc_ctrl),
      .operand (rd_cur),
      .sum_ff  (nsum)
   );

   // growth rule on the finished sum, the cell arrives on the read port
   always_comb begin
      twice_sum  = {nsum, 1'b0};
      band_mid   = 12'(procreation_ff) + 12'(stability_ff);
      fall       = (nsum < procreation_ff) || (nsum > stability_ff);
      grow       = !fall && (twice_sum < band_mid);
      old_scaled = {rd_cur, 8'd0};
      up_val     = 17'(old_scaled) + 17'(step_ff);
      if (fall) begin
         new_pix = (step_ff > old_scaled) ? 8'd0 : 8'((old_scaled - step_ff) >> 8);
      end else if (grow) begin
         new_pix = up_val[16] ? clis_pkg::PIX_MAX : up_val[15:8];
      end else begin
         new_pix = rd_cur;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == clis_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      tap_in        = tap_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      buffer_in     = buffer_ff;
      loaded_in     = loaded_ff;
      changed_in    = changed_ff;
      pixel_in      = pixel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_stable_in = rsp_stable_ff;
      acc_ctrl      = '0;
      wr_a          = 1'b0;
      wr_b          = 1'b0;
      ram_wdata     = pixel_ff;
      case (state_ff)
         clis_pkg::ST_IDLE: begin
            if (accept) begin
               pixel_in       = req_tdata;
               tap_in         = '0;
               acc_ctrl.clear = 1'b1;
               state_in       = loaded_ff ? clis_pkg::ST_SUM : clis_pkg::ST_LOAD;
            end
         end
         clis_pkg::ST_LOAD: begin
            if (out_free) begin
               wr_a          = 1'b1;
               wr_b          = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_pixel_in  = pixel_ff;
               rsp_last_in   = frame_last;
               rsp_stable_in = 1'b0;
               if (frame_last) begin
                  loaded_in  = 1'b1;
                  buffer_in  = 1'b0;
                  changed_in = 1'b0;
               end
               state_in = clis_pkg::ST_IDLE;
            end
         end
         clis_pkg::ST_SUM: begin
            // read data follows its address in the next cycle
            acc_ctrl.add = (tap_ff != '0);
            tap_in       = tap_ff + 4'd1;
            if (tap_ff == clis_pkg::TAP_OWN) begin
               state_in = clis_pkg::ST_UPDATE;
            end
         end
         clis_pkg::ST_UPDATE: begin
            ram_wdata = new_pix;
            if (out_free) begin
               wr_a          = buffer_ff;
               wr_b          = !buffer_ff;
               rsp_valid_in  = 1'b1;
               rsp_pixel_in  = new_pix;
               rsp_last_in   = frame_last;
               rsp_stable_in = 1'b0;
               if (new_pix != rd_cur) begin
                  changed_in = 1'b1;
               end
               if (frame_last) begin
                  rsp_stable_in = exit_stable_ff && !changed_ff && (new_pix == rd_cur);
                  buffer_in     = !buffer_ff;
                  changed_in    = 1'b0;
               end
               state_in = clis_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = clis_pkg::ST_IDLE;
         end
      endcase
      // raster advance after each finished word
      if ((state_ff == clis_pkg::ST_LOAD || state_ff == clis_pkg::ST_UPDATE) && out_free) begin
         if (frame_last) begin
            row_in = '0;
            col_in = '0;
         end else if (col_is_last) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      // a dimension write restarts the frame
      if (csr_wr_en && (csr_index == clis_pkg::REG_WIDTH ||
                        csr_index == clis_pkg::REG_HEIGHT)) begin
         row_in     = '0;
         col_in     = '0;
         changed_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clis_pkg::ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         buffer_ff    <= 1'b0;
         loaded_ff    <= 1'b0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tap_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         buffer_ff    <= buffer_in;
         loaded_ff    <= loaded_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
         tap_ff       <= tap_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pixel_ff      <= pixel_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_stable_ff <= rsp_stable_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         procreation_ff <= clis_pkg::RST_PROCREATION;
         stability_ff   <= clis_pkg::RST_STABILITY;
         step_ff        <= clis_pkg::RST_STEP;
         exit_stable_ff <= 1'b0;
         width_ff       <= clis_pkg::RST_WIDTH;
         height_ff      <= clis_pkg::RST_HEIGHT;
      end else if (csr_wr_en) begin
         case (csr_index)
            clis_pkg::REG_PROCREATION: procreation_ff <= csr_wr_data[10:0];
            clis_pkg::REG_STABILITY:   stability_ff   <= csr_wr_data[10:0];
            clis_pkg::REG_STEP:        step_ff        <= csr_wr_data;
            clis_pkg::REG_EXIT_STABLE: exit_stable_ff <= csr_wr_data[0];
            clis_pkg::REG_WIDTH:       width_ff       <= csr_wr_data[8:0];
            clis_pkg::REG_HEIGHT:      height_ff      <= csr_wr_data[8:0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_stable_ff;

endmodule

>>> rtl/clis_check.sv
// ----------------------------------------------------------------------------
// clis_check
// Port-level checks of the continuous life image step block, bound to the
// top level.
// ----------------------------------------------------------------------------
module clis_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // stable flag only on the last pixel of a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("stable flag outside frame end");

   // one word in flight: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind continuous_life_image_step_top clis_check u_clis_check (.*);
